// ----- src/mcl_pkg.sv -----
// Shared types and constants for the mip chain layout block.
// No dependencies; used by every module of the block.
package mcl_pkg;

    localparam int MAX_LEVELS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        FMT_NONE  = 2'd0,
        FMT_RGBA8 = 2'd1,
        FMT_BC1   = 2'd2,
        FMT_BC3   = 2'd3
    } mcl_fmt_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_REQ  = 2'd1,
        ST_ROW_OVF  = 2'd2,
        ST_SHORT    = 2'd3
    } mcl_status_t;

    localparam logic [2:0] SHIFT_RGBA8 = 3'd2;
    localparam logic [2:0] SHIFT_BC1   = 3'd3;
    localparam logic [2:0] SHIFT_BC3   = 3'd4;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic [31:0] base_width;
        logic [31:0] base_height;
        logic [5:0]  level_count;
        logic [47:0] storage_bytes;
    } mcl_req_t;

    typedef struct packed {
        logic [4:0]  level_index;
        logic [31:0] level_width;
        logic [31:0] level_height;
        logic [31:0] row_bytes;
        logic [31:0] row_count;
        logic [47:0] byte_offset;
        logic [1:0]  status;
        logic        last;
    } mcl_res_t;

    // classified request handed from front to back
    typedef struct packed {
        logic        bad;
        logic        block;
        logic [2:0]  unit_shift;
        logic [31:0] width;
        logic [31:0] height;
        logic [5:0]  levels;
        logic [47:0] storage;
    } mcl_cmd_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_BAD,
        B_CALC,
        B_MUL,
        B_CHECK
    } mcl_state_t;

endpackage

// ----- src/mcl_front.sv -----
// Front end: accepts layout requests, classifies them and queues commands.
// Depends on mcl_pkg.
module mcl_front #(
    parameter int MAX_LEVELS = mcl_pkg::MAX_LEVELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mcl_pkg::mcl_req_t req,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output mcl_pkg::mcl_cmd_t cmd
);

    localparam int PtrW = (mcl_pkg::QUEUE_DEPTH > 1) ? $clog2(mcl_pkg::QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(mcl_pkg::QUEUE_DEPTH + 1);

    mcl_pkg::mcl_cmd_t q_reg [mcl_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    mcl_pkg::mcl_cmd_t new_cmd;
    logic              push, pop;

    always_comb
    begin
        new_cmd.width   = req.base_width;
        new_cmd.height  = req.base_height;
        new_cmd.levels  = req.level_count;
        new_cmd.storage = req.storage_bytes;
        new_cmd.block   = 1'b0;
        new_cmd.unit_shift = mcl_pkg::SHIFT_RGBA8;
        unique case (mcl_pkg::mcl_fmt_t'(req.pixel_format))
            mcl_pkg::FMT_NONE:  new_cmd.unit_shift = mcl_pkg::SHIFT_RGBA8;
            mcl_pkg::FMT_RGBA8: new_cmd.unit_shift = mcl_pkg::SHIFT_RGBA8;
            mcl_pkg::FMT_BC1:
            begin
                new_cmd.block      = 1'b1;
                new_cmd.unit_shift = mcl_pkg::SHIFT_BC1;
            end
            mcl_pkg::FMT_BC3:
            begin
                new_cmd.block      = 1'b1;
                new_cmd.unit_shift = mcl_pkg::SHIFT_BC3;
            end
            default: new_cmd.unit_shift = mcl_pkg::SHIFT_RGBA8;
        endcase
        new_cmd.bad = (req.pixel_format == mcl_pkg::FMT_NONE) ||
                      (req.base_width == 32'd0) || (req.base_height == 32'd0) ||
                      (req.level_count == 6'd0) ||
                      (req.level_count > 6'(MAX_LEVELS));
    end

    assign req_stall = (cnt_reg == CntW'(mcl_pkg::QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(mcl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(mcl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// ----- src/mcl_back.sv -----
// Back end: walks the mip levels of one command and drives the result register.
// Depends on mcl_pkg.
module mcl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  mcl_pkg::mcl_cmd_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output mcl_pkg::mcl_res_t res
);

    mcl_pkg::mcl_state_t state_reg, state_next;
    mcl_pkg::mcl_cmd_t   cmd_reg, cmd_next;
    logic [4:0]          level_reg, level_next;
    logic [5:0]          remain_reg, remain_next;
    logic [47:0]         offset_reg, offset_next;
    logic [31:0]         w_reg, w_next;
    logic [31:0]         h_reg, h_next;
    logic [31:0]         rb_reg, rb_next;
    logic [31:0]         down_reg, down_next;
    logic                ovf_reg, ovf_next;
    logic [63:0]         bytes_reg, bytes_next;
    logic                res_valid_reg, res_valid_next;
    mcl_pkg::mcl_res_t   res_reg, res_next;

    logic [31:0] w_sh, h_sh, w_lvl, h_lvl, across, down;
    logic [32:0] w_pad, h_pad;
    logic [35:0] rb_wide;
    logic [47:0] avail;
    logic        slot_free;

    assign slot_free = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        w_sh    = cmd_reg.width >> level_reg;
        h_sh    = cmd_reg.height >> level_reg;
        w_lvl   = (w_sh == 32'd0) ? 32'd1 : w_sh;
        h_lvl   = (h_sh == 32'd0) ? 32'd1 : h_sh;
        w_pad   = {1'b0, w_lvl} + 33'd3;
        h_pad   = {1'b0, h_lvl} + 33'd3;
        across  = cmd_reg.block ? {1'b0, w_pad[32:2]} : w_lvl;
        down    = cmd_reg.block ? {1'b0, h_pad[32:2]} : h_lvl;
        rb_wide = {4'd0, across} << cmd_reg.unit_shift;
        avail   = cmd_reg.storage - offset_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        level_next     = level_reg;
        remain_next    = remain_reg;
        offset_next    = offset_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        rb_next        = rb_reg;
        down_next      = down_reg;
        ovf_next       = ovf_reg;
        bytes_next     = bytes_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        cmd_take       = 1'b0;
        unique case (state_reg)
            mcl_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take    = 1'b1;
                    cmd_next    = cmd;
                    level_next  = '0;
                    remain_next = cmd.levels;
                    offset_next = '0;
                    state_next  = cmd.bad ? mcl_pkg::B_BAD : mcl_pkg::B_CALC;
                end
            end
            mcl_pkg::B_BAD:
            begin
                if (slot_free)
                begin
                    res_next        = '0;
                    res_next.status = mcl_pkg::ST_BAD_REQ;
                    res_next.last   = 1'b1;
                    res_valid_next  = 1'b1;
                    state_next      = mcl_pkg::B_IDLE;
                end
            end
            mcl_pkg::B_CALC:
            begin
                w_next     = w_lvl;
                h_next     = h_lvl;
                rb_next    = rb_wide[31:0];
                down_next  = down;
                ovf_next   = (rb_wide[35:32] != 4'd0);
                state_next = mcl_pkg::B_MUL;
            end
            mcl_pkg::B_MUL:
            begin
                bytes_next = rb_reg * down_reg;
                state_next = mcl_pkg::B_CHECK;
            end
            mcl_pkg::B_CHECK:
            begin
                if (slot_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next             = '0;
                    res_next.level_index = level_reg;
                    res_next.last        = 1'b1;
                    if (ovf_reg)
                    begin
                        res_next.status = mcl_pkg::ST_ROW_OVF;
                        state_next      = mcl_pkg::B_IDLE;
                    end
                    else if (bytes_reg > {16'd0, avail})
                    begin
                        res_next.status = mcl_pkg::ST_SHORT;
                        state_next      = mcl_pkg::B_IDLE;
                    end
                    else
                    begin
                        res_next.level_width  = w_reg;
                        res_next.level_height = h_reg;
                        res_next.row_bytes    = rb_reg;
                        res_next.row_count    = down_reg;
                        res_next.byte_offset  = offset_reg;
                        res_next.status       = mcl_pkg::ST_OK;
                        res_next.last         = (remain_reg == 6'd1);
                        offset_next           = offset_reg + bytes_reg[47:0];
                        level_next            = level_reg + 5'd1;
                        remain_next           = remain_reg - 6'd1;
                        state_next = (remain_reg == 6'd1) ? mcl_pkg::B_IDLE
                                                          : mcl_pkg::B_CALC;
                    end
                end
            end
            default: state_next = mcl_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcl_pkg::B_IDLE;
            level_reg     <= '0;
            remain_reg    <= '0;
            offset_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            remain_reg    <= remain_next;
            offset_reg    <= offset_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        w_reg     <= w_next;
        h_reg     <= h_next;
        rb_reg    <= rb_next;
        down_reg  <= down_next;
        ovf_reg   <= ovf_next;
        bytes_reg <= bytes_next;
        res_reg   <= res_next;
    end

endmodule

// ----- src/mip_chain_layout.sv -----
// Top level of the mip chain layout block: request queue front, level walker back.
// Depends on mcl_pkg, mcl_front and mcl_back.
//
//   channel  | handshake            | word
//   ---------+----------------------+--------------------------
//   req      | req_valid/req_stall  | mcl_req_t, one request
//   res      | res_valid/res_stall  | mcl_res_t, one mip level
//
// In the level walker each good level passes through a compute step, a 32x32
// multiply and a storage check; a rejected request goes to a single error word.
// A two-entry command queue lets requests be taken while the walker is busy.
// Reset clears the queue, walker state and result valid.
// A stalled result holds the walker in its check (or error) step until the word is taken.
module mip_chain_layout #(
    parameter int MAX_LEVELS = mcl_pkg::MAX_LEVELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  mcl_pkg::mcl_req_t req,
    output logic              res_valid,
    input  logic              res_stall,
    output mcl_pkg::mcl_res_t res
);

    logic              cmd_valid;
    logic              cmd_take;
    mcl_pkg::mcl_cmd_t cmd;

    mcl_front #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    mcl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
